### hdl/assert_macros.svh
// Assertion macros shared by the frustum projection RTL.
// Depends on nothing; the using module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frustum core check failed");
`define FPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frustum core check failed");
`else
`define FPC_ASSERT(lbl, prop)
`define FPC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hdl/fpc_pkg.sv
// Shared types and constants of the frustum projection core.
// Used by the register bank, the set-up pipeline, the divider and the top level.
package fpc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int QBITS      = 32;
  localparam int DEN_W      = 64;
  localparam int NUM_W      = DEN_W + QBITS;
  // Input register, five set-up stages, one stage per quotient bit, output register.
  localparam int PIPE_DEPTH = QBITS + 7;

  localparam logic [31:0] SCALE      = 32'(64'd1 << FRAC_BITS);
  localparam logic [30:0] NEAR_RESET = 31'(64'd1 << FRAC_BITS);
  localparam logic [30:0] FAR_RESET  = 31'(64'd100 << FRAC_BITS);
  localparam logic [31:0] SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG    = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_PERSP     = 2'd0,
    MODE_ORTHO     = 2'd1,
    MODE_INV_PERSP = 2'd2,
    MODE_INV_ORTHO = 2'd3
  } proj_mode_t;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_NEAR  = 3'd1,
    REG_FAR   = 3'd2,
    REG_RIGHT = 3'd3,
    REG_TOP   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    proj_mode_t  mode;
    logic [30:0] near_d;
    logic [30:0] far_d;
    logic [30:0] right_h;
    logic [30:0] top_h;
  } cfg_t;

  typedef struct packed {
    logic clip;
    logic err;
  } meta_t;

  typedef struct packed {
    logic             num_neg;
    logic             den_neg;
    logic             ovf;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

### hdl/fpc_cfg_regs.sv
// Configuration register bank of the frustum projection core.
// Depends on fpc_pkg.
module fpc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output fpc_pkg::cfg_t  cfg
);
  import fpc_pkg::*;

  cfg_t regs;

  assign cfg_ready = !rst;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode    <= MODE_PERSP;
      regs.near_d  <= NEAR_RESET;
      regs.far_d   <= FAR_RESET;
      regs.right_h <= NEAR_RESET;
      regs.top_h   <= NEAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MODE:  regs.mode    <= proj_mode_t'(cfg_data[1:0]);
        REG_NEAR:  regs.near_d  <= cfg_data[30:0];
        REG_FAR:   regs.far_d   <= cfg_data[30:0];
        REG_RIGHT: regs.right_h <= cfg_data[30:0];
        REG_TOP:   regs.top_h   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/fpc_front.sv
// Set-up pipeline: operand magnitudes, coefficient products and the
// numerator and denominator of each coordinate. Depends on fpc_pkg.
module fpc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  fpc_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  logic [31:0]                 in_x,
  input  logic [31:0]                 in_y,
  input  logic [31:0]                 in_z,
  output logic                        req_valid,
  output fpc_pkg::div_req_t [2:0]     req,
  output fpc_pkg::meta_t              req_meta
);
  import fpc_pkg::*;

  typedef struct packed {
    logic             num_neg;
    logic             den_neg;
    logic [63:0]      a1;
    logic [31:0]      mul;
    logic [DEN_W-1:0] den;
  } lane_s2_t;

  typedef struct packed {
    logic             num_neg;
    logic             den_neg;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [DEN_W-1:0] den;
  } lane_s3_t;

  typedef struct packed {
    logic             num_neg;
    logic             den_neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lane_s4_t;

  // Stage 0: input register.
  logic        s0_valid;
  logic [31:0] s0_x, s0_y, s0_z;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else     s0_valid <= in_valid;
    s0_x <= in_x;
    s0_y <= in_y;
    s0_z <= in_z;
  end

  // Stage 1: magnitudes and all first-level products.
  logic [31:0] ax, ay, az, fmn_w, fpn;
  logic [30:0] afmn, cx, cy;
  logic [34:0] zz2, v1n;
  logic [33:0] zn, zfar;
  logic        fwd, clip1, errc1;

  always_comb begin
    ax    = s0_x[31] ? (32'd0 - s0_x) : s0_x;
    ay    = s0_y[31] ? (32'd0 - s0_y) : s0_y;
    az    = s0_z[31] ? (32'd0 - s0_z) : s0_z;
    fmn_w = {1'b0, cfg.far_d} - {1'b0, cfg.near_d};
    afmn  = fmn_w[31] ? 31'(32'd0 - fmn_w) : fmn_w[30:0];
    fpn   = {1'b0, cfg.far_d} + {1'b0, cfg.near_d};
    // -v of the orthographic depth term, v = -2z - (f + n).
    zz2   = {{2{s0_z[31]}}, s0_z, 1'b0};
    v1n   = zz2 + {3'b000, fpn};
    zn    = {{2{s0_z[31]}}, s0_z} + {3'b000, cfg.near_d};
    zfar  = {{2{s0_z[31]}}, s0_z} + {3'b000, cfg.far_d};
    fwd   = (cfg.mode == MODE_PERSP) || (cfg.mode == MODE_ORTHO);
    clip1 = fwd && ((!zn[33] && (zn != 34'd0)) || zfar[33]);
    errc1 = (cfg.far_d == cfg.near_d) || (cfg.right_h == 31'd0) || (cfg.top_h == 31'd0) ||
            ((cfg.mode == MODE_PERSP) && (s0_z == 32'd0)) ||
            ((cfg.mode == MODE_INV_PERSP) && (cfg.near_d == 31'd0));
    unique case (cfg.mode)
      MODE_PERSP: begin
        cx = cfg.near_d;
        cy = cfg.near_d;
      end
      MODE_INV_PERSP: begin
        cx = cfg.far_d;
        cy = cfg.far_d;
      end
      MODE_ORTHO, MODE_INV_ORTHO: begin
        cx = cfg.right_h;
        cy = cfg.top_h;
      end
    endcase
  end

  logic        s1_valid, s1_clip, s1_err;
  logic        s1_xneg, s1_yneg, s1_xpos, s1_ypos, s1_zneg, s1_zpos, s1_fmn_neg, s1_v1neg;
  logic [31:0] s1_ax, s1_ay, s1_fpn;
  logic [30:0] s1_afmn;
  logic [34:0] s1_av1;
  logic [63:0] s1_px, s1_py, s1_rz, s1_tz, s1_fz, s1_sz, s1_fn;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= s0_valid;
    s1_clip    <= clip1;
    s1_err     <= errc1;
    s1_xneg    <= s0_x[31];
    s1_yneg    <= s0_y[31];
    s1_xpos    <= !s0_x[31] && (s0_x != 32'd0);
    s1_ypos    <= !s0_y[31] && (s0_y != 32'd0);
    s1_zneg    <= s0_z[31];
    s1_zpos    <= !s0_z[31] && (s0_z != 32'd0);
    s1_fmn_neg <= fmn_w[31];
    s1_v1neg   <= !v1n[34] && (v1n != 35'd0);
    s1_av1     <= v1n[34] ? (35'd0 - v1n) : v1n;
    s1_ax      <= ax;
    s1_ay      <= ay;
    s1_fpn     <= fpn;
    s1_afmn    <= afmn;
    s1_px      <= 64'(ax) * 64'(cx);
    s1_py      <= 64'(ay) * 64'(cy);
    s1_rz      <= 64'(cfg.right_h) * 64'(az);
    s1_tz      <= 64'(cfg.top_h) * 64'(az);
    s1_fz      <= 64'(afmn) * 64'(az);
    s1_sz      <= 64'(fpn) * 64'(az);
    s1_fn      <= 64'(cfg.far_d) * 64'(cfg.near_d);
  end

  // Stage 2: signed sums and selection of each coordinate's operands.
  logic [63:0] fpns, sum_fz, diff_fz, rdiff_fz, d_abs, av3, sa, sb, s_abs;
  logic        d_neg, d_zero, v3_pos, s_neg, err2;
  lane_s2_t    l2 [3];

  always_comb begin
    fpns     = 64'(s1_fpn) << FRAC_BITS;
    sum_fz   = s1_fz + fpns;
    diff_fz  = s1_fz - fpns;
    rdiff_fz = fpns - s1_fz;
    // Inverse perspective denominator d = z(f - n) - (f + n)S; the product
    // z(f - n) is negative when exactly one of its factors is.
    if (s1_zneg != s1_fmn_neg) begin
      d_abs  = sum_fz;
      d_neg  = sum_fz != 64'd0;
      d_zero = sum_fz == 64'd0;
      v3_pos = !rdiff_fz[63] && (rdiff_fz != 64'd0);
      av3    = rdiff_fz[63] ? diff_fz : rdiff_fz;
    end else begin
      d_abs  = diff_fz[63] ? rdiff_fz : diff_fz;
      d_neg  = diff_fz[63];
      d_zero = diff_fz == 64'd0;
      v3_pos = sum_fz != 64'd0;
      av3    = sum_fz;
    end
    // Perspective depth numerator (f + n)|z| combined with 2fn by the sign of z.
    sa = s1_sz;
    sb = s1_fn << 1;
    if (s1_zpos) begin
      s_abs = sa + sb;
      s_neg = 1'b0;
    end else if (sb >= sa) begin
      s_abs = sb - sa;
      s_neg = 1'b0;
    end else begin
      s_abs = sa - sb;
      s_neg = 1'b1;
    end
    err2 = s1_err || ((cfg.mode == MODE_INV_PERSP) && d_zero);

    unique case (cfg.mode)
      MODE_PERSP: begin
        l2[0] = '{s1_xneg, s1_zpos, s1_px, SCALE, s1_rz};
        l2[1] = '{s1_yneg, s1_zpos, s1_py, SCALE, s1_tz};
        l2[2] = '{s_neg, s1_fmn_neg != s1_zneg, s_abs, SCALE, s1_fz};
      end
      MODE_ORTHO: begin
        l2[0] = '{s1_xneg, 1'b0, 64'(s1_ax), SCALE, 64'(cfg.right_h)};
        l2[1] = '{s1_yneg, 1'b0, 64'(s1_ay), SCALE, 64'(cfg.top_h)};
        l2[2] = '{s1_v1neg, s1_fmn_neg, 64'(s1_av1), SCALE, 64'(s1_afmn)};
      end
      MODE_INV_PERSP: begin
        l2[0] = '{s1_xpos, d_neg, s1_px << 1, 32'(cfg.right_h), d_abs};
        l2[1] = '{s1_ypos, d_neg, s1_py << 1, 32'(cfg.top_h), d_abs};
        l2[2] = '{1'b0, d_neg, s1_fn << 1, SCALE, d_abs};
      end
      MODE_INV_ORTHO: begin
        l2[0] = '{s1_xneg, 1'b0, s1_px, 32'd1, 64'(SCALE)};
        l2[1] = '{s1_yneg, 1'b0, s1_py, 32'd1, 64'(SCALE)};
        l2[2] = '{v3_pos, 1'b0, av3, 32'd1, 64'(SCALE) << 1};
      end
    endcase
  end

  logic     s2_valid, s3_valid, s4_valid, s5_valid;
  meta_t    s2_meta, s3_meta, s4_meta, s5_meta;
  lane_s2_t s2_lane [3];
  lane_s3_t s3_lane [3];
  lane_s4_t s4_lane [3];
  div_req_t [2:0] s5_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
    s2_meta <= '{s1_clip, err2};
    s3_meta <= s2_meta;
    s4_meta <= s3_meta;
    s5_meta <= s4_meta;
  end

  // Stages 3 to 5: split wide product, its sum, and the quotient range check.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      s2_lane[l]         <= l2[l];
      s3_lane[l].num_neg <= s2_lane[l].num_neg;
      s3_lane[l].den_neg <= s2_lane[l].den_neg;
      s3_lane[l].den     <= s2_lane[l].den;
      s3_lane[l].lo      <= 64'(s2_lane[l].a1[31:0]) * 64'(s2_lane[l].mul);
      s3_lane[l].hi      <= 64'(s2_lane[l].a1[63:32]) * 64'(s2_lane[l].mul);
      s4_lane[l].num_neg <= s3_lane[l].num_neg;
      s4_lane[l].den_neg <= s3_lane[l].den_neg;
      s4_lane[l].den     <= s3_lane[l].den;
      s4_lane[l].num     <= NUM_W'(s3_lane[l].lo) + (NUM_W'(s3_lane[l].hi) << 32);
      s5_lane[l].num_neg <= s4_lane[l].num_neg;
      s5_lane[l].den_neg <= s4_lane[l].den_neg;
      s5_lane[l].den     <= s4_lane[l].den;
      s5_lane[l].num     <= s4_lane[l].num;
      s5_lane[l].ovf     <= s4_lane[l].num[NUM_W-1:QBITS] >= s4_lane[l].den;
    end
  end

  assign req_valid = s5_valid;
  assign req       = s5_lane;
  assign req_meta  = s5_meta;

endmodule

### hdl/fpc_div_pipe.sv
// Pipelined restoring divider for the three coordinates, one quotient bit
// per stage, with saturation and the output register. Depends on fpc_pkg.
module fpc_div_pipe (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  fpc_pkg::div_req_t [2:0]  req,
  input  fpc_pkg::meta_t           req_meta,
  output logic                     done,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic                     clipped,
  output logic                     div_error
);
  import fpc_pkg::*;

  typedef struct packed {
    logic             num_neg;
    logic             den_neg;
    logic             ovf;
    logic [DEN_W-1:0] rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] q;
    logic [DEN_W-1:0] den;
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t s);
    div_lane_t   r;
    logic [DEN_W:0] t;
    logic [DEN_W:0] dif;
    r     = s;
    t     = {s.rem, s.low[QBITS-1]};
    dif   = t - {1'b0, s.den};
    r.low = {s.low[QBITS-2:0], 1'b0};
    if (!dif[DEN_W]) begin
      r.rem = dif[DEN_W-1:0];
      r.q   = {s.q[QBITS-2:0], 1'b1};
    end else begin
      r.rem = t[DEN_W-1:0];
      r.q   = {s.q[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] saturate(div_lane_t s, logic err);
    logic neg;
    neg = s.num_neg ^ s.den_neg;
    priority if (err)  return 32'd0;
    else if (s.ovf)    return neg ? SAT_NEG : SAT_POS;
    else if (neg)      return (s.q > SAT_NEG) ? SAT_NEG : (32'd0 - s.q);
    else               return s.q[31] ? SAT_POS : s.q;
  endfunction

  div_lane_t [2:0] st [QBITS+1];
  logic            vld [QBITS+1];
  meta_t           mt  [QBITS+1];

  // The partial remainder starts as the numerator's upper part, already below
  // the divisor unless the quotient is out of range.
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign st[0][l] = '{req[l].num_neg, req[l].den_neg, req[l].ovf,
                        req[l].num[NUM_W-1:QBITS], req[l].num[QBITS-1:0],
                        {QBITS{1'b0}}, req[l].den};
  end
  assign vld[0] = req_valid;
  assign mt[0]  = req_meta;

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
      mt[k+1]    <= mt[k];
      st[k+1][0] <= div_step(st[k][0]);
      st[k+1][1] <= div_step(st[k][1]);
      st[k+1][2] <= div_step(st[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[QBITS];
    out_x     <= saturate(st[QBITS][0], mt[QBITS].err);
    out_y     <= saturate(st[QBITS][1], mt[QBITS].err);
    out_z     <= saturate(st[QBITS][2], mt[QBITS].err);
    clipped   <= mt[QBITS].clip;
    div_error <= mt[QBITS].err;
  end

endmodule

### hdl/frustum_project_and_clip_core.sv
// Top level of the symmetric-frustum point transform.
// Depends on fpc_pkg, fpc_cfg_regs, fpc_front, fpc_div_pipe and assert_macros.svh.
//
// Usage
// - Points arrive on in_x, in_y, in_z (signed Q16.16) and are taken at a clock
//   edge where start is high and busy is low. busy is high only during reset,
//   so a new point may be issued on every clock.
// - Each request produces exactly one result: out_x, out_y, out_z, clipped and
//   div_error are valid for the single cycle in which done is high. The result
//   cannot be held off, so the consumer must take it in that cycle.
// - Throughput is one point per cycle. A point passes an input register and five
//   set-up stages, then the restoring divider, which resolves one quotient bit
//   per stage over 32 stages.
// - The transform and frustum are set through the cfg_valid/cfg_ready channel:
//   cfg_index selects mode, near, far, right half-width or top half-height.
//   Writes must be made only while no point is in flight; not enforced.
// - Synchronous reset empties the pipeline and loads the default frustum
//   (perspective, near 1.0, far 100.0, half-widths 1.0).
`include "assert_macros.svh"
module frustum_project_and_clip_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               clipped,
  output logic               div_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import fpc_pkg::*;

  cfg_t           cfg;
  logic           req_valid;
  div_req_t [2:0] req;
  meta_t          req_meta;

  assign busy = rst;

  fpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (start && !busy),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .req_valid (req_valid),
    .req       (req),
    .req_meta  (req_meta)
  );

  fpc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_meta  (req_meta),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .clipped   (clipped),
    .div_error (div_error)
  );

  `FPC_ASSERT(a_result_follows, (start && !busy) |-> ##PIPE_DEPTH done)
  `FPC_ASSERT(a_no_spurious_result, done |-> $past(start && !busy, PIPE_DEPTH))
  `FPC_ASSERT(a_error_zeroes, (done && div_error) |-> ({out_x, out_y, out_z} == '0))
  `FPC_ASSERT_ALWAYS(a_reset_empties, rst |=> !done)

endmodule

### tb/sv/frustum_project_and_clip_core_tb.sv
// Self-checking testbench for frustum_project_and_clip_core: every request is predicted
// with wide integer arithmetic and compared with the single result it causes.
// Depends on fpc_pkg and the core RTL only.
module frustum_project_and_clip_core_tb;
  import fpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 45;
  localparam int STALL_LIMIT  = 5000;

  typedef struct {
    logic signed [31:0] x, y, z;
  } point_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        clip, err;
  } proj_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, clipped, div_error, cfg_ready;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic signed [31:0] out_x, out_y, out_z;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = REG_MODE;
  logic [31:0] cfg_data = '0;

  proj_mode_t  cur_mode  = MODE_PERSP;
  logic [30:0] cur_near  = NEAR_RESET;
  logic [30:0] cur_far   = FAR_RESET;
  logic [30:0] cur_right = 31'(SCALE);
  logic [30:0] cur_top   = 31'(SCALE);

  point_t       point_q[$];
  proj_result_t projected_q[$];
  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  no_gaps = 1'b0;

  frustum_project_and_clip_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .clipped(clipped), .div_error(div_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Truncating signed quotient, saturated to 32 bits; a zero divisor gives zero.
  function automatic logic [31:0] sat_quot(logic num_neg, logic [127:0] num,
                                           logic den_neg, logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return '0;
    q = num / {64'd0, den};
    if (num_neg != den_neg) begin
      if (q > 128'h8000_0000) return SAT_NEG;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) return SAT_POS;
    return q[31:0];
  endfunction

  function automatic proj_result_t project_point(point_t p);
    longint x, y, z, n, f, r, t, fmn, d, v;
    logic [63:0] fpn, az, a, b, s;
    logic sneg;
    proj_result_t e;
    x = p.x; y = p.y; z = p.z;
    n = longint'(cur_near); f = longint'(cur_far);
    r = longint'(cur_right); t = longint'(cur_top);
    fmn = f - n;
    fpn = 64'(f + n);
    e = '{default: '0};
    e.err = (f == n) || r == 0 || t == 0;
    case (cur_mode)
      MODE_PERSP: begin
        e.clip = (z > -n) || (z < -f);
        if (z == 0) e.err = 1'b1;
        if (!e.err) begin
          az = mag(z);
          a = fpn * az;
          b = 64'(2 * f * n);
          sneg = 1'b0;
          e.x = sat_quot(x < 0, 128'(64'(n) * mag(x)) << FRAC_BITS, z > 0, 64'(r) * az);
          e.y = sat_quot(y < 0, 128'(64'(n) * mag(y)) << FRAC_BITS, z > 0, 64'(t) * az);
          // The sum wraps at 64 bits exactly as the hardware numerator does.
          if (z > 0) s = a + b;
          else if (b >= a) s = b - a;
          else begin
            s = a - b;
            sneg = 1'b1;
          end
          e.z = sat_quot(sneg, 128'(s) << FRAC_BITS, (fmn < 0) != (z < 0), mag(fmn) * az);
        end
      end
      MODE_ORTHO: begin
        e.clip = (z > -n) || (z < -f);
        if (!e.err) begin
          v = -2 * z - longint'(fpn);
          e.x = sat_quot(x < 0, 128'(mag(x)) << FRAC_BITS, 1'b0, 64'(r));
          e.y = sat_quot(y < 0, 128'(mag(y)) << FRAC_BITS, 1'b0, 64'(t));
          e.z = sat_quot(v < 0, 128'(mag(v)) << FRAC_BITS, fmn < 0, mag(fmn));
        end
      end
      MODE_INV_PERSP: begin
        if (n == 0) e.err = 1'b1;
        if (!e.err) begin
          d = z * fmn - longint'(fpn << FRAC_BITS);
          if (d == 0) e.err = 1'b1;
        end
        if (!e.err) begin
          e.z = sat_quot(1'b0, 128'(64'(2 * f * n)) << FRAC_BITS, d < 0, mag(d));
          e.x = sat_quot(x > 0, 128'(mag(x) * 64'(f) * 2) * 128'(r), d < 0, mag(d));
          e.y = sat_quot(y > 0, 128'(mag(y) * 64'(f) * 2) * 128'(t), d < 0, mag(d));
        end
      end
      default: begin
        if (!e.err) begin
          v = z * fmn + longint'(fpn << FRAC_BITS);
          e.x = sat_quot(x < 0, 128'(mag(x)) * 128'(r), 1'b0, 64'(SCALE));
          e.y = sat_quot(y < 0, 128'(mag(y)) * 128'(t), 1'b0, 64'(SCALE));
          e.z = sat_quot(v > 0, 128'(mag(v)), 1'b0, 64'(SCALE) * 2);
        end
      end
    endcase
    if (e.err) begin
      e.x = '0;
      e.y = '0;
      e.z = '0;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (mode %0d)", what, got, want, cur_mode);
    mismatches++;
  endtask

  // Request driver: accepted points are predicted at the edge that takes them.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) projected_q.push_back(project_point('{in_x, in_y, in_z}));
      if (point_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 33)) begin
        point_t p;
        p = point_q.pop_front();
        start <= 1'b1;
        in_x <= p.x;
        in_y <= p.y;
        in_z <= p.z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (projected_q.size() == 0) begin
        report_mismatch("unexpected result", out_x, '0);
      end else begin
        proj_result_t e;
        e = projected_q.pop_front();
        if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
        if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
        if (clipped !== e.clip) report_mismatch("clipped", 32'(clipped), 32'(e.clip));
        if (div_error !== e.err) report_mismatch("div_error", 32'(div_error), 32'(e.err));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Each write returns only at the edge after its accepting edge, so back-to-back calls
  // never drive the channel twice in one time step.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:  cur_mode = proj_mode_t'(data[1:0]);
      REG_NEAR:  cur_near = data[30:0];
      REG_FAR:   cur_far = data[30:0];
      REG_RIGHT: cur_right = data[30:0];
      REG_TOP:   cur_top = data[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (point_q.size() > 0 || start || projected_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    return $signed($urandom) >>> $urandom_range(0, 24);
  endfunction

  function automatic point_t rand_point();
    point_t p;
    longint n, f;
    n = longint'(cur_near);
    f = longint'(cur_far);
    p.x = rand_coord();
    p.y = rand_coord();
    case ($urandom_range(0, 3))
      0: p.z = -32'($urandom_range(0, 32'(f)));
      1: case ($urandom_range(0, 4))
           0: p.z = 32'(-n);
           1: p.z = 32'(-n + 1);
           2: p.z = 32'(-f);
           3: p.z = 32'(-f - 1);
           default: p.z = '0;
         endcase
      2: p.z = rand_coord();
      default: begin
        p.x = $urandom;
        p.y = $urandom;
        p.z = $urandom;
      end
    endcase
    return p;
  endfunction

  initial begin
    logic [31:0] fr[4];
    point_t p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Points go out under the default frustum before any register is touched.
    repeat (12) point_q.push_back(rand_point());
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 8; k++) begin
        case (k)
          0: fr = '{32'h0001_0000, 32'h0064_0000, 32'h0001_0000, 32'h0001_0000};
          // Far three times near makes the inverse perspective divisor vanish at z = 2.0.
          1: fr = '{32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_8000};
          2: fr = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF};
          3: fr = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001};
          4: fr = '{32'h0003_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000};
          5: fr = '{32'h0000_0000, 32'h0004_0000, 32'h0000_0000, 32'h0001_0000};
          default: fr = '{$urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0100_0000),
                          $urandom_range(1, 32'h0010_0000), $urandom_range(1, 32'h0010_0000)};
        endcase
        write_reg(REG_MODE, 32'(m) | ($urandom & 32'hFFFF_FFFC));
        write_reg(REG_NEAR, fr[0]);
        write_reg(REG_FAR, fr[1]);
        write_reg(REG_RIGHT, fr[2]);
        write_reg(REG_TOP, fr[3]);
        no_gaps = (m == 1);
        if (k == 1) begin
          point_q.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000});
          point_q.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
          point_q.push_back('{32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000});
          point_q.push_back('{-32'sh0000_8000, 32'sh0000_4000, -32'sh0003_0000});
          point_q.push_back('{32'sh0000_1000, -32'sh0000_2000, -32'sh0003_0001});
          point_q.push_back('{32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000});
        end
        repeat (12) point_q.push_back(rand_point());
        wait_idle();
      end
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
